FILE: src/bdq_pkg.sv
package bdq_pkg;

	// Default sizes, handed to the top level parameters.
	localparam int DEF_CAPACITY  = 16;
	localparam int DEF_WORD_BITS = 32;

	// Operation codes carried in the op field of a request word.
	localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [2:0] OP_POP_FRONT  = 3'd2;
	localparam logic [2:0] OP_POP_BACK   = 3'd3;
	localparam logic [2:0] OP_CLEAR      = 3'd4;

	// Status codes carried in the status field of a response word.
	localparam logic [1:0] STATUS_DONE  = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

endpackage

FILE: src/bdq_req_if.sv
interface bdq_req_if #(
	parameter int WORD_BITS = 32
);
	logic                 valid;
	logic                 ready;
	logic [2:0]           op;
	logic [WORD_BITS-1:0] push_word;

	modport source (output valid, op, push_word, input ready);
	modport sink   (input valid, op, push_word, output ready);
endinterface

FILE: src/bdq_rsp_if.sv
interface bdq_rsp_if #(
	parameter int WORD_BITS = 32,
	parameter int COUNT_BITS = 5
);
	logic                  valid;
	logic                  ready;
	logic [1:0]            status;
	logic [WORD_BITS-1:0]  popped_word;
	logic [WORD_BITS-1:0]  front_word;
	logic [WORD_BITS-1:0]  back_word;
	logic [COUNT_BITS-1:0] entry_total;
	logic                  is_empty;
	logic                  is_full;

	modport source (output valid, status, popped_word, front_word, back_word, entry_total,
		is_empty, is_full, input ready);
	modport sink   (input valid, status, popped_word, front_word, back_word, entry_total,
		is_empty, is_full, output ready);
endinterface

FILE: src/bdq_store.sv
module bdq_store #(
	parameter int DEPTH = 16,
	parameter int WORD_BITS = 32,
	parameter int AW = 4
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  logic [WORD_BITS-1:0] wr_data,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output logic [WORD_BITS-1:0] rd_data
);

	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] rd_data_q;

	// One write port and one registered read port; read data holds until the next read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: src/bounded_double_ended_queue.sv
// Bounded double-ended queue of data words.
// The req channel carries one operation per word: push front, push back,
// pop front, pop back or clear, with the word to insert on a push.
// The rsp channel returns exactly one word per request: the status, the
// popped word, the front and back words, the entry count and empty/full flags.
// A push into a full queue or a pop from an empty queue is refused and leaves
// the contents unchanged.
// On accept the entry memory is written or read and the stage register loads;
// in the execute state, once it is free, the response register loads from the
// stage and memory read data. No request is taken while one is executing.
// The front and back words are cached in registers, so only a pop needs a
// memory read (for the new front or back entry).
// Reset clears the count, the pointers and the control state; the memory is
// not cleared, and no entry is read before it is written.
// When the receiver stalls, the response register holds its word; a new
// request is still accepted, and its result waits until the register frees.
module bounded_double_ended_queue
	import bdq_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY,
	parameter int WORD_BITS = DEF_WORD_BITS
) (
	input logic clk,
	input logic arst_n,
	bdq_req_if.sink   req,
	bdq_rsp_if.source rsp
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
	localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE_CNT  = CW'(1);

	function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] idx);
		return (idx == LAST_IDX) ? '0 : idx + AW'(1);
	endfunction

	function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] idx);
		return (idx == '0) ? LAST_IDX : idx - AW'(1);
	endfunction

	state_t state_q;

	logic [AW-1:0]        head_q, tail_q, head_d, tail_d;
	logic [CW-1:0]        count_q, count_d;
	logic [WORD_BITS-1:0] front_q, back_q;

	logic [1:0]           status_d, status_s1;
	logic [WORD_BITS-1:0] popped_d, popped_s1;
	logic [WORD_BITS-1:0] front_d, back_d, front_s1, back_s1;
	logic                 front_mem_d, back_mem_d, front_mem_s1, back_mem_s1;

	logic                 wr_en, rd_en;
	logic [AW-1:0]        wr_addr, rd_addr;
	logic [WORD_BITS-1:0] rd_data;

	logic                 out_valid_q;
	logic [1:0]           out_status_q;
	logic [WORD_BITS-1:0] out_popped_q, out_front_q, out_back_q;
	logic [CW-1:0]        out_count_q;

	logic                 accept, out_free, finish;
	logic                 is_empty_now, is_full_now;
	logic [WORD_BITS-1:0] front_fin, back_fin;

	assign req.ready    = (state_q == ST_IDLE);
	assign accept       = req.valid && req.ready;
	assign out_free     = !out_valid_q || rsp.ready;
	assign finish       = (state_q == ST_EXEC) && out_free;
	assign is_empty_now = (count_q == '0);
	assign is_full_now  = (count_q == CAP_CNT);

	// Decode the operation, plan the memory access and the next pointers.
	always_comb begin
		head_d      = head_q;
		tail_d      = tail_q;
		count_d     = count_q;
		status_d    = STATUS_DONE;
		popped_d    = '0;
		front_d     = front_q;
		back_d      = back_q;
		front_mem_d = 1'b0;
		back_mem_d  = 1'b0;
		wr_en       = 1'b0;
		wr_addr     = head_q;
		rd_en       = 1'b0;
		rd_addr     = head_q;
		case (req.op)
			OP_PUSH_FRONT: begin
				if (is_full_now) begin
					status_d = STATUS_FULL;
				end else begin
					head_d  = idx_dec(head_q);
					wr_en   = accept;
					wr_addr = idx_dec(head_q);
					count_d = count_q + ONE_CNT;
					front_d = req.push_word;
					if (is_empty_now) begin
						back_d = req.push_word;
					end
				end
			end
			OP_PUSH_BACK: begin
				if (is_full_now) begin
					status_d = STATUS_FULL;
				end else begin
					tail_d  = idx_inc(tail_q);
					wr_en   = accept;
					wr_addr = idx_inc(tail_q);
					count_d = count_q + ONE_CNT;
					back_d  = req.push_word;
					if (is_empty_now) begin
						front_d = req.push_word;
					end
				end
			end
			OP_POP_FRONT: begin
				if (is_empty_now) begin
					status_d = STATUS_EMPTY;
				end else begin
					popped_d = front_q;
					head_d   = idx_inc(head_q);
					count_d  = count_q - ONE_CNT;
					if (count_q == ONE_CNT) begin
						front_d = '0;
						back_d  = '0;
					end else begin
						rd_en       = accept;
						rd_addr     = idx_inc(head_q);
						front_mem_d = 1'b1;
					end
				end
			end
			OP_POP_BACK: begin
				if (is_empty_now) begin
					status_d = STATUS_EMPTY;
				end else begin
					popped_d = back_q;
					tail_d   = idx_dec(tail_q);
					count_d  = count_q - ONE_CNT;
					if (count_q == ONE_CNT) begin
						front_d = '0;
						back_d  = '0;
					end else begin
						rd_en      = accept;
						rd_addr    = idx_dec(tail_q);
						back_mem_d = 1'b1;
					end
				end
			end
			OP_CLEAR: begin
				head_d  = '0;
				tail_d  = LAST_IDX;
				count_d = '0;
				front_d = '0;
				back_d  = '0;
			end
			default: begin
			end
		endcase
	end

	// Front and back words after the operation, taking memory data where a pop read it.
	assign front_fin = front_mem_s1 ? rd_data : front_s1;
	assign back_fin  = back_mem_s1 ? rd_data : back_s1;

	bdq_store #(
		.DEPTH(CAPACITY),
		.WORD_BITS(WORD_BITS),
		.AW(AW)
	) u_store (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(req.push_word),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Sequencer, pointers, count and cached end words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= LAST_IDX;
			count_q <= '0;
			front_q <= '0;
			back_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						head_q  <= head_d;
						tail_q  <= tail_d;
						count_q <= count_d;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (out_free) begin
						front_q <= front_fin;
						back_q  <= back_fin;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Stage register between the memory access and the response.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1    <= status_d;
			popped_s1    <= popped_d;
			front_s1     <= front_d;
			back_s1      <= back_d;
			front_mem_s1 <= front_mem_d;
			back_mem_s1  <= back_mem_d;
		end
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_status_q <= status_s1;
			out_popped_q <= popped_s1;
			out_front_q  <= front_fin;
			out_back_q   <= back_fin;
			out_count_q  <= count_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.popped_word = out_popped_q;
	assign rsp.front_word  = out_front_q;
	assign rsp.back_word   = out_back_q;
	assign rsp.entry_total = out_count_q;
	assign rsp.is_empty    = (out_count_q == '0);
	assign rsp.is_full     = (out_count_q == CAP_CNT);

endmodule

FILE: src/bdq_checker.sv
module bdq_checker
	import bdq_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY,
	parameter int WORD_BITS = DEF_WORD_BITS,
	parameter int CW = $clog2(DEF_CAPACITY + 1)
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 rsp_valid,
	input logic                 rsp_ready,
	input logic [1:0]           status,
	input logic [WORD_BITS-1:0] popped_word,
	input logic [WORD_BITS-1:0] front_word,
	input logic [WORD_BITS-1:0] back_word,
	input logic [CW-1:0]        entry_total,
	input logic                 is_empty,
	input logic                 is_full
);

	localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

	// The count never exceeds the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (entry_total <= CAP_CNT))
		else $error("entry count beyond capacity");

	// An empty queue reports zero end words.
	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && is_empty) |-> (front_word == '0 && back_word == '0))
		else $error("empty queue reports nonzero end words");

	// A refused operation pops nothing.
	a_refused_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status != STATUS_DONE) |-> (popped_word == '0))
		else $error("refused operation returns a popped word");

	// Full refusal only when full, empty refusal only when empty.
	a_refusal_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((status != STATUS_FULL || is_full) && (status != STATUS_EMPTY || is_empty)))
		else $error("refusal status disagrees with flags");

	// A stalled response holds its status, popped word and count.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(status) && $stable(popped_word)
			&& $stable(entry_total)))
		else $error("stalled response changed");

endmodule

bind bounded_double_ended_queue bdq_checker #(
	.CAPACITY(CAPACITY),
	.WORD_BITS(WORD_BITS),
	.CW(CW)
) u_bdq_checker (
	.clk(clk),
	.arst_n(arst_n),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.status(rsp.status),
	.popped_word(rsp.popped_word),
	.front_word(rsp.front_word),
	.back_word(rsp.back_word),
	.entry_total(rsp.entry_total),
	.is_empty(rsp.is_empty),
	.is_full(rsp.is_full)
);

FILE: tb/bdq_result_checker.sv
module bdq_result_checker
	import bdq_pkg::*;
#(
	parameter int CAPACITY   = DEF_CAPACITY,
	parameter int WORD_BITS  = DEF_WORD_BITS,
	parameter int COUNT_BITS = 5
) (
	input  logic clk,
	input  logic arst_n,
	bdq_req_if   req,
	bdq_rsp_if   rsp,
	output int   mismatch_count,
	output int   pending_results
);

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [1:0]            status;
		logic [WORD_BITS-1:0]  popped_word;
		logic [WORD_BITS-1:0]  front_word;
		logic [WORD_BITS-1:0]  back_word;
		logic [COUNT_BITS-1:0] entry_total;
		logic                  is_empty;
		logic                  is_full;
	} deque_result_t;

	// Shadow copy of the deque: circular store, front position and fill level.
	logic [WORD_BITS-1:0] shadow_slots [CAPACITY];
	int                   front_slot;
	int                   held_count;

	deque_result_t expected_results [$];
	deque_result_t want;
	int            error_total;
	int            result_index;

	assign mismatch_count = error_total;

	// Applies one operation to the shadow deque and returns the result word it should give.
	function automatic deque_result_t apply_operation(input logic [2:0] op,
			input logic [WORD_BITS-1:0] word);
		deque_result_t r;
		r.status      = STATUS_DONE;
		r.popped_word = '0;
		r.front_word  = '0;
		r.back_word   = '0;
		case (op)
			OP_PUSH_FRONT: begin
				if (held_count >= CAPACITY) begin
					r.status = STATUS_FULL;
				end else begin
					front_slot = (front_slot + CAPACITY - 1) % CAPACITY;
					shadow_slots[front_slot] = word;
					held_count++;
				end
			end
			OP_PUSH_BACK: begin
				if (held_count >= CAPACITY) begin
					r.status = STATUS_FULL;
				end else begin
					shadow_slots[(front_slot + held_count) % CAPACITY] = word;
					held_count++;
				end
			end
			OP_POP_FRONT: begin
				if (held_count == 0) begin
					r.status = STATUS_EMPTY;
				end else begin
					r.popped_word = shadow_slots[front_slot];
					front_slot = (front_slot + 1) % CAPACITY;
					held_count--;
				end
			end
			OP_POP_BACK: begin
				if (held_count == 0) begin
					r.status = STATUS_EMPTY;
				end else begin
					r.popped_word = shadow_slots[(front_slot + held_count - 1) % CAPACITY];
					held_count--;
				end
			end
			OP_CLEAR: begin
				held_count = 0;
				front_slot = 0;
			end
			default: begin
				// Unused codes leave the deque as it is and just report it.
			end
		endcase
		if (held_count > 0) begin
			r.front_word = shadow_slots[front_slot];
			r.back_word  = shadow_slots[(front_slot + held_count - 1) % CAPACITY];
		end
		r.entry_total = COUNT_BITS'(held_count);
		r.is_empty    = (held_count == 0);
		r.is_full     = (held_count >= CAPACITY);
		return r;
	endfunction

	task automatic check_field(input string field, input logic [63:0] expected_value,
			input logic [63:0] actual_value);
		if (actual_value !== expected_value) begin
			$display("%0t ns: result %0d %s mismatch, expected %h actual %h",
				$time, result_index, field, expected_value, actual_value);
			error_total++;
		end
	endtask

	// Compare each accepted result word, then predict for each accepted request word.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_slot   = 0;
			held_count   = 0;
			error_total  = 0;
			result_index = 0;
			expected_results.delete();
			pending_results <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t ns: result %0d arrived with nothing expected, actual status %h",
						$time, result_index, rsp.status);
					error_total++;
				end else begin
					want = expected_results.pop_front();
					check_field("status", 64'(want.status), 64'(rsp.status));
					check_field("popped_word", 64'(want.popped_word), 64'(rsp.popped_word));
					check_field("front_word", 64'(want.front_word), 64'(rsp.front_word));
					check_field("back_word", 64'(want.back_word), 64'(rsp.back_word));
					check_field("entry_total", 64'(want.entry_total), 64'(rsp.entry_total));
					check_field("is_empty", 64'(want.is_empty), 64'(rsp.is_empty));
					check_field("is_full", 64'(want.is_full), 64'(rsp.is_full));
				end
				result_index++;
			end
			if (req.valid && req.ready) begin
				expected_results.push_back(apply_operation(req.op, req.push_word));
			end
			pending_results <= expected_results.size();
		end
	end

endmodule

FILE: tb/bounded_double_ended_queue_tb.sv
module bounded_double_ended_queue_tb
	import bdq_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY     = DEF_CAPACITY;
	localparam int WORD_BITS    = DEF_WORD_BITS;
	localparam int COUNT_BITS   = $clog2(CAPACITY + 1);
	localparam int RANDOM_WORDS = 1150;
	localparam int MAX_IDLE     = 18;
	localparam int CYCLE_LIMIT  = 400000;

	logic clk;
	logic arst_n;
	int   mismatch_count;
	int   pending_results;
	int   cycle_count;
	bit   sender_eager;
	bit   receiver_eager;

	bdq_req_if #(.WORD_BITS(WORD_BITS)) req_ch ();
	bdq_rsp_if #(.WORD_BITS(WORD_BITS), .COUNT_BITS(COUNT_BITS)) rsp_ch ();

	bounded_double_ended_queue #(
		.CAPACITY (CAPACITY),
		.WORD_BITS(WORD_BITS)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	bdq_result_checker #(
		.CAPACITY  (CAPACITY),
		.WORD_BITS (WORD_BITS),
		.COUNT_BITS(COUNT_BITS)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req_ch),
		.rsp            (rsp_ch),
		.mismatch_count (mismatch_count),
		.pending_results(pending_results)
	);

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic int idle_cycles(input bit eager);
		return eager ? 0 : $urandom_range(0, MAX_IDLE);
	endfunction

	// Mostly random data, with all-zero and all-one words mixed in.
	function automatic logic [WORD_BITS-1:0] pick_word();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0) begin
			return '0;
		end else if (r == 1) begin
			return '1;
		end
		return WORD_BITS'($urandom);
	endfunction

	// Pushes take push_pct percent of the push/pop traffic, so the level drifts up or down.
	function automatic logic [2:0] pick_op(input int push_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < 3) begin
			return OP_CLEAR + 3'($urandom_range(1, 3));
		end else if (r < 5) begin
			return OP_CLEAR;
		end else if ($urandom_range(0, 99) < push_pct) begin
			return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
		end
		return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
	endfunction

	// Offers one request word after a drawn gap and returns at the edge that accepts it.
	task automatic send_word(input logic [2:0] op, input logic [WORD_BITS-1:0] word);
		int gap;
		gap = idle_cycles(sender_eager);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.op        <= op;
		req_ch.push_word <= word;
		req_ch.valid     <= 1'b1;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	// Response side: stall a drawn number of cycles before taking each result word.
	initial begin
		int stall;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = idle_cycles(receiver_eager);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
		end
	end

	// Stimulus: directed corner cases, then phases that fill, drain or churn the deque.
	initial begin
		int sent;
		int push_pct;
		int phase_len;
		int r;
		sent             = 0;
		cycle_count      = 0;
		sender_eager     = 1'b0;
		receiver_eager   = 1'b0;
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.op        = OP_PUSH_FRONT;
		req_ch.push_word = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Refused pops on an empty deque, then both extremes of the data word.
		send_word(OP_POP_FRONT, '0);
		send_word(OP_POP_BACK, '1);
		send_word(OP_PUSH_FRONT, '1);
		send_word(OP_PUSH_BACK, '0);
		send_word(OP_POP_FRONT, '0);
		send_word(OP_POP_BACK, '0);
		send_word(OP_CLEAR, '0);

		// Fill from both ends, then refused pushes and an unused code while full.
		for (int i = 0; i < CAPACITY; i++) begin
			send_word((i % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK,
				(i % 4 == 1) ? {(WORD_BITS/2){2'b10}} : pick_word());
		end
		send_word(OP_PUSH_FRONT, pick_word());
		send_word(OP_PUSH_BACK, pick_word());
		send_word(OP_CLEAR + 3'd3, pick_word());
		send_word(OP_CLEAR, '0);

		while (sent < RANDOM_WORDS) begin
			r = $urandom_range(0, 2);
			push_pct       = (r == 0) ? 25 : ((r == 1) ? 50 : 80);
			sender_eager   = ($urandom_range(0, 3) == 0);
			receiver_eager = ($urandom_range(0, 3) == 0);
			phase_len      = $urandom_range(20, 60);
			repeat (phase_len) begin
				send_word(pick_op(push_pct), pick_word());
				sent++;
			end
		end
		req_ch.valid <= 1'b0;

		// Drain: wait for every predicted result word, then a few quiet cycles.
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

FILE: filelist.f
src/bdq_pkg.sv
src/bdq_req_if.sv
src/bdq_rsp_if.sv
src/bdq_store.sv
src/bounded_double_ended_queue.sv
src/bdq_checker.sv
tb/bdq_result_checker.sv
tb/bounded_double_ended_queue_tb.sv
